// ----- rtl/accel_calibrate_tilt_core_assert.svh -----
// Assertion macros shared by the accelerometer tilt core.
`ifndef ACCEL_CALIBRATE_TILT_CORE_ASSERT_SVH
`define ACCEL_CALIBRATE_TILT_CORE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define ACT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("accel tilt core check failed");

// Checked on every rising edge, reset included.
`define ACT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("accel tilt core check failed");

`endif

// ----- rtl/act_pkg.sv -----
// Types, constants and tables shared by the accelerometer tilt core.
package act_pkg;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int ATAN_TBL_LEN = 24;

  // Rotator datapath and angle accumulator widths.
  localparam int CW = 27;
  localparam int AW = 27;

  localparam logic signed [16:0] DEG180_Q8 = 17'sd46080;
  localparam logic signed [16:0] DEG90_Q8 = 17'sd23040;
  localparam logic signed [AW-1:0] DEG180_Q16 = 27'sd11796480;

  // Register indexes of the configuration channel.
  localparam logic [7:0] CFG_OFFSET_X = 8'd0;
  localparam logic [7:0] CFG_OFFSET_Y = 8'd1;
  localparam logic [7:0] CFG_OFFSET_Z = 8'd2;
  localparam logic [7:0] CFG_GAIN_X = 8'd3;
  localparam logic [7:0] CFG_GAIN_Y = 8'd4;
  localparam logic [7:0] CFG_GAIN_Z = 8'd5;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest.
  localparam logic signed [AW-1:0] ATAN_TBL [ATAN_TBL_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379, 27'sd117304, 27'sd58666, 27'sd29335,
    27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
    27'sd917, 27'sd458, 27'sd229, 27'sd115,
    27'sd57, 27'sd29, 27'sd14, 27'sd7,
    27'sd4, 27'sd2, 27'sd1, 27'sd0
  };

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    sample_t z;
    sample_t y;
    sample_t x;
  } axes_t;

  typedef struct packed {
    sample_t off_x;
    sample_t off_y;
    sample_t off_z;
    logic [15:0] gain_x;
    logic [15:0] gain_y;
    logic [15:0] gain_z;
  } calib_cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic is_fixed;
    logic signed [16:0] fixed_ang;
  } lane_t;

  typedef struct packed {
    axes_t norm;
    lane_t pitch;
    lane_t roll;
  } cordic_word_t;

  typedef struct packed {
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
    axes_t norm;
  } result_t;

endpackage

// ----- rtl/act_calib.sv -----
// Offset removal, gain multiply, rounding and saturation for the three axes.
module act_calib
  import act_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  calib_cfg_t cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  axes_t      in_axes,
  output logic       out_valid,
  input  logic       out_ready,
  output axes_t      out_axes
);

  logic v1, v2, v3;
  logic r1, r2, r3;
  logic signed [16:0] diff [3];
  logic signed [33:0] prod [3];
  axes_t norm;
  sample_t raw_a [3];
  sample_t off_a [3];
  logic [15:0] gain_a [3];

  function automatic sample_t round_sat(input logic signed [33:0] p);
    logic signed [34:0] s;
    logic signed [34:0] q;
    s = {p[33], p} + 35'sd8192;
    q = s >>> 14;
    if (q > 35'sd32767) return 16'sh7FFF;
    else if (q < -35'sd32768) return 16'sh8000;
    else return q[15:0];
  endfunction

  assign raw_a[0] = in_axes.x;
  assign raw_a[1] = in_axes.y;
  assign raw_a[2] = in_axes.z;
  assign off_a[0] = cfg.off_x;
  assign off_a[1] = cfg.off_y;
  assign off_a[2] = cfg.off_z;
  assign gain_a[0] = cfg.gain_x;
  assign gain_a[1] = cfg.gain_y;
  assign gain_a[2] = cfg.gain_z;

  assign r3 = ~v3 | out_ready;
  assign r2 = ~v2 | r3;
  assign r1 = ~v1 | r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (r1 && in_valid) begin
        diff[i] <= $signed({raw_a[i][15], raw_a[i]}) - $signed({off_a[i][15], off_a[i]});
      end
      if (r2 && v1) begin
        prod[i] <= diff[i] * $signed({1'b0, gain_a[i]});
      end
    end
    if (r3 && v2) begin
      norm.x <= round_sat(prod[0]);
      norm.y <= round_sat(prod[1]);
      norm.z <= round_sat(prod[2]);
    end
  end

  assign out_valid = v3;
  assign out_axes = norm;

endmodule

// ----- rtl/act_angle_prep.sv -----
// Sets up both angle lanes: special cases, scaling and half-turn fold.
module act_angle_prep
  import act_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  axes_t        in_axes,
  output logic         out_valid,
  input  logic         out_ready,
  output cordic_word_t out_word
);

  logic valid;
  cordic_word_t word;

  function automatic lane_t prep_lane(input sample_t num, input sample_t den);
    lane_t l;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = {{(CW-24){den[15]}}, den, 8'b0};
    ys = {{(CW-24){num[15]}}, num, 8'b0};
    l.is_fixed = 1'b0;
    l.fixed_ang = '0;
    l.x = xs;
    l.y = ys;
    l.ang = '0;
    if (num == 16'sd0) begin
      l.is_fixed = 1'b1;
      l.fixed_ang = den[15] ? DEG180_Q8 : 17'sd0;
    end else if (den == 16'sd0) begin
      l.is_fixed = 1'b1;
      l.fixed_ang = num[15] ? -DEG90_Q8 : DEG90_Q8;
    end else if (den[15]) begin
      // Fold the vector into the right half plane and start from +-180.
      l.x = -xs;
      l.y = -ys;
      l.ang = num[15] ? -DEG180_Q16 : DEG180_Q16;
    end
    return l;
  endfunction

  assign in_ready = ~valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word.norm <= in_axes;
      word.pitch <= prep_lane(in_axes.x, in_axes.z);
      word.roll <= prep_lane(in_axes.y, in_axes.z);
    end
  end

  assign out_valid = valid;
  assign out_word = word;

endmodule

// ----- rtl/act_cordic_cell.sv -----
// One vectoring rotation step for both angle lanes, with its own register.
module act_cordic_cell
  import act_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cordic_word_t in_word,
  output logic         out_valid,
  input  logic         out_ready,
  output cordic_word_t out_word
);

  logic valid;
  cordic_word_t word;

  function automatic lane_t rotate(input lane_t l);
    lane_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = l.x >>> STAGE;
    ys = l.y >>> STAGE;
    r = l;
    if (!l.y[CW-1]) begin
      r.x = l.x + ys;
      r.y = l.y - xs;
      r.ang = l.ang + ATAN_TBL[STAGE];
    end else begin
      r.x = l.x - ys;
      r.y = l.y + xs;
      r.ang = l.ang - ATAN_TBL[STAGE];
    end
    return r;
  endfunction

  assign in_ready = ~valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word.norm <= in_word.norm;
      word.pitch <= rotate(in_word.pitch);
      word.roll <= rotate(in_word.roll);
    end
  end

  assign out_valid = valid;
  assign out_word = word;

endmodule

// ----- rtl/act_angle_out.sv -----
// Rounds and clamps both angles and holds the finished result word.
module act_angle_out
  import act_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cordic_word_t in_word,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_result
);

  logic valid;
  result_t result;

  function automatic logic signed [16:0] finish(input lane_t l);
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] q;
    s = l.ang + 27'sd128;
    q = s >>> 8;
    if (l.is_fixed) return l.fixed_ang;
    else if (q > 27'sd46080) return DEG180_Q8;
    else if (q < -27'sd46080) return -DEG180_Q8;
    else return q[16:0];
  endfunction

  assign in_ready = ~valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result.norm <= in_word.norm;
      result.pitch <= finish(in_word.pitch);
      result.roll <= finish(in_word.roll);
    end
  end

  assign out_valid = valid;
  assign out_result = result;

endmodule

// ----- rtl/accel_calibrate_tilt_core.sv -----
// Top level of the accelerometer calibration and tilt angle core.
//
//   Channel   Direction  Payload
//   s_axis    in         raw_x, raw_y, raw_z (one sample word)
//   m_axis    out        norm_x, norm_y, norm_z, pitch_deg, roll_deg
//   cfg       in         cfg_index, cfg_data (offset and gain registers)
//
// The core takes one word per cycle and keeps taking words as long as the
// downstream side drains them. The pipeline holds three calibration stages,
// one angle setup stage, one stage per rotation cell and one rounding stage
// that also serves as the output register. Every stage has its own valid
// bit, so a stall at m_axis only holds the stages that are full and empty
// stages upstream keep filling. Reset empties all stages and loads the
// calibration registers with their default values.
`include "accel_calibrate_tilt_core_assert.svh"

module accel_calibrate_tilt_core
  import act_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Sample stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  input  logic [47:0] s_axis_tdata,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // norm_x [15:0], norm_y [31:16], norm_z [47:32], pitch_deg [64:48],
  // roll_deg [81:65], zero fill [87:82]
  output logic [87:0] m_axis_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Calibration registers. The y offset holds the negated additive offset,
  // so every axis subtracts its offset.
  calib_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_x <= 16'sd804;
      cfg.off_y <= -16'sd307;
      cfg.off_z <= 16'sd883;
      cfg.gain_x <= 16'd17069;
      cfg.gain_y <= 16'd16423;
      cfg.gain_z <= 16'd16135;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET_X: cfg.off_x <= cfg_data;
        CFG_OFFSET_Y: cfg.off_y <= cfg_data;
        CFG_OFFSET_Z: cfg.off_z <= cfg_data;
        CFG_GAIN_X: cfg.gain_x <= cfg_data;
        CFG_GAIN_Y: cfg.gain_y <= cfg_data;
        CFG_GAIN_Z: cfg.gain_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  axes_t in_axes;
  axes_t norm_axes;
  logic norm_valid, norm_ready;

  assign in_axes.x = s_axis_tdata[15:0];
  assign in_axes.y = s_axis_tdata[31:16];
  assign in_axes.z = s_axis_tdata[47:32];

  act_calib u_calib (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_axes   (in_axes),
    .out_valid (norm_valid),
    .out_ready (norm_ready),
    .out_axes  (norm_axes)
  );

  // Chain of rotation cells; link 0 is fed by the angle setup stage.
  cordic_word_t chain_word [ANGLE_ITERATIONS+1];
  logic chain_valid [ANGLE_ITERATIONS+1];
  logic chain_ready [ANGLE_ITERATIONS+1];

  act_angle_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_valid),
    .in_ready  (norm_ready),
    .in_axes   (norm_axes),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_word  (chain_word[0])
  );

  for (genvar g = 0; g < ANGLE_ITERATIONS; g++) begin : g_cell
    act_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_word   (chain_word[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_word  (chain_word[g+1])
    );
  end

  result_t result;

  act_angle_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[ANGLE_ITERATIONS]),
    .in_ready   (chain_ready[ANGLE_ITERATIONS]),
    .in_word    (chain_word[ANGLE_ITERATIONS]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  assign m_axis_tdata = {6'b0, result};

  // An empty output register means no stage can be stalled.
  `ACT_ASSERT(a_ready_when_drained, !m_axis_tvalid |-> s_axis_tready)
  // Angles stay within a half turn either way.
  `ACT_ASSERT(a_pitch_range, m_axis_tvalid |-> ($signed(m_axis_tdata[64:48]) <= DEG180_Q8 && $signed(m_axis_tdata[64:48]) >= -DEG180_Q8))
  `ACT_ASSERT(a_roll_range, m_axis_tvalid |-> ($signed(m_axis_tdata[81:65]) <= DEG180_Q8 && $signed(m_axis_tdata[81:65]) >= -DEG180_Q8))
  // A gain write lands in its register on the next edge.
  `ACT_ASSERT(a_gain_x_write, cfg_valid && cfg_index == CFG_GAIN_X |=> cfg.gain_x == $past(cfg_data))
  // Reset leaves no result word behind.
  `ACT_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_axis_tvalid)

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the accelerometer calibration and tilt angle core.
module tb;
  import act_pkg::*;

  localparam int ITERS = ANGLE_ITERATIONS_DEF;
  // Three calibration stages, angle setup, one stage per rotation, rounding.
  localparam int LATENCY = ITERS + 5;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // One line of the directed table: a register write or a sample word, and
  // for some samples the result written out by hand.
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  idx;
    logic [15:0] val;
    axes_t       raw;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the calibration registers, kept in step with every write.
  calib_cfg_t  cal;
  result_t     pending_tilt[$];
  dir_row_t    dir_rows[$];
  int          mismatch_count = 0;
  int          rx_idle_pct = 0;
  int          rx_stall_left = 0;
  int          stall_cycles = 0;

  // atan(2^-i) in degrees with 16 fraction bits.
  longint atan_deg_q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  accel_calibrate_tilt_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offset removal and gain, rounded half up and saturated to 16 bits.
  function automatic sample_t calib_axis(sample_t raw, sample_t off, logic [15:0] gain);
    longint d;
    longint r;
    d = longint'(raw) - longint'(off);
    r = (d * longint'(gain) + 8192) >>> 14;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return sample_t'(r);
  endfunction

  // Vectoring rotation of (den, num); the angle comes out in degrees Q.8.
  function automatic logic signed [16:0] tilt_angle(longint num, longint den);
    longint x;
    longint y;
    longint nx;
    longint ny;
    longint ang;
    longint r;
    if (num == 0) return (den < 0) ? 17'sd46080 : 17'sd0;
    if (den == 0) return (num > 0) ? 17'sd23040 : -17'sd23040;
    x = den * 256;
    y = num * 256;
    ang = 0;
    // Left half plane: turn the vector half a circle and start from +-180.
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = (num > 0) ? 64'sd11796480 : -64'sd11796480;
    end
    for (int i = 0; i < ITERS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        ang += atan_deg_q16[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        ang -= atan_deg_q16[i];
      end
      x = nx;
      y = ny;
    end
    r = (ang + 128) >>> 8;
    if (r > 46080) r = 46080;
    if (r < -46080) r = -46080;
    return r[16:0];
  endfunction

  function automatic result_t predict_tilt(axes_t raw);
    result_t r;
    r.norm.x = calib_axis(raw.x, cal.off_x, cal.gain_x);
    r.norm.y = calib_axis(raw.y, cal.off_y, cal.gain_y);
    r.norm.z = calib_axis(raw.z, cal.off_z, cal.gain_z);
    r.pitch = tilt_angle(longint'(r.norm.x), longint'(r.norm.z));
    r.roll = tilt_angle(longint'(r.norm.y), longint'(r.norm.z));
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void add_write(logic [7:0] idx, logic [15:0] val);
    dir_row_t row;
    row = '{kind: ROW_WRITE, idx: idx, val: val, raw: '0, typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_sample(sample_t rx, sample_t ry, sample_t rz);
    dir_row_t row;
    row = '{kind: ROW_SAMPLE, idx: '0, val: '0, raw: '0, typed: 1'b0, want: '0};
    row.raw = '{z: rz, y: ry, x: rx};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known(sample_t rx, sample_t ry, sample_t rz, sample_t nx,
                                    sample_t ny, sample_t nz, logic signed [16:0] pitch,
                                    logic signed [16:0] roll);
    dir_row_t row;
    row = '{kind: ROW_SAMPLE, idx: '0, val: '0, raw: '0, typed: 1'b1, want: '0};
    row.raw = '{z: rz, y: ry, x: rx};
    row.want.norm = '{z: nz, y: ny, x: nx};
    row.want.pitch = pitch;
    row.want.roll = roll;
    dir_rows.push_back(row);
  endfunction

  // Random axis value: mostly full range, often right at or next to the
  // offset so that zero numerators and denominators come up.
  function automatic sample_t rand_axis(sample_t off);
    case ($urandom_range(9))
      6, 7: return off + sample_t'($urandom_range(6)) - 16'sd3;
      8: return off;
      9: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_offset();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return 16'($urandom_range(4000)) - 16'd2000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3, 4: return 16'd16384 + 16'($urandom_range(6000)) - 16'd3000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One sample word; the expectation is queued when the core takes it.
  task automatic push_sample(axes_t raw, result_t want);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= raw;
    do @(posedge clk); while (!s_axis_tready);
    pending_tilt.push_back(want);
  endtask

  task automatic hold_sender(int n);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending and wait until every result is out and the pipe is empty.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_tilt.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OFFSET_X: cal.off_x = val;
      CFG_OFFSET_Y: cal.off_y = val;
      CFG_OFFSET_Z: cal.off_z = val;
      CFG_GAIN_X: cal.gain_x = val;
      CFG_GAIN_Y: cal.gain_y = val;
      CFG_GAIN_Z: cal.gain_z = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Downstream stalls come in random bursts.
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if ($urandom_range(99) < rx_idle_pct) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= $urandom_range(12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker: every word taken is matched against the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[81:0];
      if (pending_tilt.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = pending_tilt.pop_front();
        check_field("norm_x", longint'(want.norm.x), longint'(got.norm.x));
        check_field("norm_y", longint'(want.norm.y), longint'(got.norm.y));
        check_field("norm_z", longint'(want.norm.z), longint'(got.norm.z));
        check_field("pitch_deg", longint'(want.pitch), longint'(got.pitch));
        check_field("roll_deg", longint'(want.roll), longint'(got.roll));
      end
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    axes_t raw;
    int tx_idle_pct;
    bit quiet;

    cal.off_x = 16'sd804;
    cal.off_y = -16'sd307;
    cal.off_z = 16'sd883;
    cal.gain_x = 16'd17069;
    cal.gain_y = 16'd16423;
    cal.gain_z = 16'd16135;

    // Default calibration: the offsets themselves give all zeros, and the
    // two largest x and y with z at its offset saturate and point straight up.
    add_known(804, -307, 883, 0, 0, 0, 0, 0);
    add_known(32767, 32767, 883, 32767, 32767, 0, 23040, 23040);
    add_sample(-32768, -32768, -32768);
    add_sample(0, 0, 0);
    // Writes to indexes past the last register leave the calibration alone.
    add_write(8'd6, 16'hffff);
    add_write(8'd255, 16'h0000);
    add_known(804, -307, 883, 0, 0, 0, 0, 0);
    // Unity calibration: corrected axes equal the raw ones.
    add_write(CFG_OFFSET_X, 16'h0000);
    add_write(CFG_OFFSET_Y, 16'h0000);
    add_write(CFG_OFFSET_Z, 16'h0000);
    add_write(CFG_GAIN_X, 16'd16384);
    add_write(CFG_GAIN_Y, 16'd16384);
    add_write(CFG_GAIN_Z, 16'd16384);
    add_known(0, 0, 100, 0, 0, 100, 0, 0);
    add_known(0, 0, -100, 0, 0, -100, 46080, 46080);
    add_known(100, -100, 0, 100, -100, 0, 23040, -23040);
    add_known(0, 0, 0, 0, 0, 0, 0, 0);
    add_sample(1, -1, -1);
    add_sample(-32768, 32767, -32768);
    add_sample(32767, -32768, 32767);
    add_sample(1000, 1000, 1000);
    add_sample(-1, 1, 32767);
    // Zero gain flattens every axis.
    add_write(CFG_GAIN_X, 16'h0000);
    add_write(CFG_GAIN_Y, 16'h0000);
    add_write(CFG_GAIN_Z, 16'h0000);
    add_known(12345, -32768, 32767, 0, 0, 0, 0, 0);
    // Extreme offsets with the largest gains.
    add_write(CFG_OFFSET_X, 16'h8000);
    add_write(CFG_OFFSET_Y, 16'h7fff);
    add_write(CFG_OFFSET_Z, 16'h8000);
    add_write(CFG_GAIN_X, 16'hffff);
    add_write(CFG_GAIN_Y, 16'hffff);
    add_write(CFG_GAIN_Z, 16'hffff);
    add_sample(32767, -32768, 32767);
    add_sample(-32768, 32767, -32768);
    add_sample(0, 0, 0);
    add_known(-32768, 32767, -32768, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rx_idle_pct = 20;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_WRITE) begin
        drain_results();
        write_reg(dir_rows[k].idx, dir_rows[k].val);
      end else begin
        push_sample(dir_rows[k].raw,
                    dir_rows[k].typed ? dir_rows[k].want : predict_tilt(dir_rows[k].raw));
      end
    end

    // Random phases, each with a fresh calibration written while idle.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_reg(CFG_OFFSET_X, rand_offset());
      write_reg(CFG_OFFSET_Y, rand_offset());
      write_reg(CFG_OFFSET_Z, rand_offset());
      write_reg(CFG_GAIN_X, rand_gain());
      write_reg(CFG_GAIN_Y, rand_gain());
      write_reg(CFG_GAIN_Z, rand_gain());
      if ($urandom_range(2) == 0) write_reg(8'($urandom_range(255, 6)), 16'($urandom));
      tx_idle_pct = $urandom_range(60, 10);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Idle-free stretches inside each phase; the last phase runs flat out.
        quiet = (ph == NUM_PHASES - 1) || ((i / 60) % 3 == 2);
        rx_idle_pct = quiet ? 0 : 30;
        if (ph == 2 && i == ITEMS_PER_PHASE / 2) drain_results();
        if (!quiet && $urandom_range(99) < tx_idle_pct) hold_sender($urandom_range(13, 1));
        raw.x = rand_axis(cal.off_x);
        raw.y = rand_axis(cal.off_y);
        raw.z = rand_axis(cal.off_z);
        push_sample(raw, predict_tilt(raw));
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
